>>> sv/ksp_pkg.sv
package ksp_pkg;

   // Table geometry
   localparam int ENTRIES = 32;
   localparam int ENTRY_W = $clog2(ENTRIES);
   localparam int SCAN_W = $clog2(ENTRIES + 1);

   // Request queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_W = $clog2(QUEUE_DEPTH);

   // Request operations
   localparam logic [2:0] OP_RX      = 3'd0;
   localparam logic [2:0] OP_TX_DONE = 3'd1;
   localparam logic [2:0] OP_START   = 3'd2;
   localparam logic [2:0] OP_TIMEOUT = 3'd3;
   localparam logic [2:0] OP_WRITE   = 3'd4;
   localparam logic [2:0] OP_READ    = 3'd5;

   // Result kinds
   localparam logic [1:0] KIND_TX     = 2'd0;
   localparam logic [1:0] KIND_VALUE  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;
   localparam logic [1:0] KIND_READ   = 2'd3;

   // Status codes
   localparam logic [2:0] ST_CONTINUE    = 3'd0;
   localparam logic [2:0] ST_OK          = 3'd1;
   localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
   localparam logic [2:0] ST_IDLE        = 3'd3;
   localparam logic [2:0] ST_SENT        = 3'd4;

   // Link bytes
   localparam logic [7:0] SYNC_BYTE   = 8'h05;
   localparam logic [7:0] FRAME_START = 8'h01;
   localparam logic [7:0] FRAME_END   = 8'h04;
   localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  data_byte;
      logic [4:0]  entry_index;
      logic [7:0]  entry_mode;
      logic [15:0] entry_address;
      logic [7:0]  entry_length;
      logic [7:0]  entry_conversion;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tx_byte;
      logic [4:0]  index;
      logic [31:0] value;
      logic [7:0]  conversion;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   // One stored table entry, written as a whole
   typedef struct packed {
      logic [7:0]  mode;
      logic [15:0] address;
      logic [7:0]  length;
      logic [7:0]  conversion;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   // Classified request handed from front to back
   typedef struct packed {
      logic [2:0]         op;
      logic [7:0]         data_byte;
      logic [4:0]         raw_index;
      logic [ENTRY_W-1:0] index;
      logic               in_range;
      entry_type          entry;
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_WIDE   = 2'd0,
      MODE_NARROW = 2'd1,
      MODE_BAD    = 2'd2
   } mode_class_type;

   // Address width of a request frame by command mode
   function automatic mode_class_type classify_mode(input logic [7:0] mode);
      mode_class_type cls;
      unique case (mode)
         8'hF7, 8'h6B, 8'h7B: cls = MODE_WIDE;
         8'hC7, 8'hCB, 8'hAE, 8'hC5,
         8'h6E, 8'h9E, 8'h33, 8'h43: cls = MODE_NARROW;
         default: cls = MODE_BAD;
      endcase
      return cls;
   endfunction

   function automatic rsp_type make_status(input logic [2:0] st);
      rsp_type r;
      r = '0;
      r.kind = KIND_STATUS;
      r.status = st;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic rsp_type make_tx(input logic [7:0] b);
      rsp_type r;
      r = '0;
      r.kind = KIND_TX;
      r.tx_byte = b;
      return r;
   endfunction

endpackage

>>> sv/kw_serial_poll_engine.sv
// Serial poll engine: keeps a table of read requests and drives a KW-style
// serial link from it.
// Requests enter on req_data and are taken at a clock edge where start is
// high and busy is low. A short queue holds up to two requests, so busy rises
// only while the sequencer is working and the queue is full.
// Results leave on rsp_data, each valid for the single cycle in which
// rsp_strobe is high; rsp_data.last marks the final result of a request.
// The receiver cannot stall, so results leave at most one per cycle.
// A taken request is registered in the queue and reaches the sequencer once
// the sequencer is idle. Table write, tx done and timeout give no result; a
// plain rx byte answers through the result register, and read entry answers
// after the registered table read. A sync byte first reads the entry's
// parameters and then sends its frame; a completed reply gives its value
// report if it has a conversion, and a chained frame follows it.
// A frame gives up to six bytes and then its sent status. A start poll scans
// the in-use flags one entry per cycle and reports the first entry in use, or
// idle once every entry has been checked. Requests are carried out one at a
// time.
// Reset clears the in-use and value-valid flags at once: every entry reads
// as unused with value all ones, and no clearing pass is needed.
module kw_serial_poll_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ksp_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ksp_pkg::rsp_type rsp_data
);

   logic             cmd_valid;
   logic             cmd_pop;
   ksp_pkg::cmd_type cmd_data;

   // Accept and classify requests
   ksp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   // Carry out requests against the table and the link
   ksp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_data   (cmd_data),
      .cmd_pop    (cmd_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

>>> sv/ksp_ram.sv
module ksp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word registered
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/ksp_front.sv
module ksp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ksp_pkg::req_type  req_data,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output ksp_pkg::cmd_type  cmd_data
);

   ksp_pkg::cmd_type slot_ff [ksp_pkg::QUEUE_DEPTH];
   logic [ksp_pkg::QUEUE_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ksp_pkg::QUEUE_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ksp_pkg::QUEUE_W:0]   count_ff, count_in;
   ksp_pkg::cmd_type cls;
   logic known;
   logic push;

   // Classify the request: drop unknown operations, check the index range
   always_comb begin
      unique case (req_data.operation)
         ksp_pkg::OP_RX, ksp_pkg::OP_TX_DONE, ksp_pkg::OP_START,
         ksp_pkg::OP_TIMEOUT, ksp_pkg::OP_WRITE, ksp_pkg::OP_READ: known = 1'b1;
         default: known = 1'b0;
      endcase
      cls.op = req_data.operation;
      cls.data_byte = req_data.data_byte;
      cls.raw_index = req_data.entry_index;
      cls.index = ksp_pkg::ENTRY_W'(req_data.entry_index);
      cls.in_range = (int'(req_data.entry_index) < ksp_pkg::ENTRIES);
      cls.entry.mode = req_data.entry_mode;
      cls.entry.address = req_data.entry_address;
      cls.entry.length = req_data.entry_length;
      cls.entry.conversion = req_data.entry_conversion;
   end

   assign busy = (count_ff == (ksp_pkg::QUEUE_W + 1)'(ksp_pkg::QUEUE_DEPTH));
   assign push = start && !busy && known;
   assign cmd_valid = (count_ff != '0);
   assign cmd_data = slot_ff[rd_ptr_ff];

   // Advance queue pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ksp_pkg::QUEUE_W'(ksp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == ksp_pkg::QUEUE_W'(ksp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Hold queued requests
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

>>> sv/ksp_back.sv
module ksp_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  ksp_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   output logic             rsp_strobe,
   output ksp_pkg::rsp_type rsp_data
);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_SCAN     = 7'b0000010,
      S_READ     = 7'b0000100,
      S_REPORT   = 7'b0001000,
      S_FRAME_RD = 7'b0010000,
      S_FRAME    = 7'b0100000,
      S_STATUS   = 7'b1000000
   } state_type;

   typedef enum logic [6:0] {
      STEP_START   = 7'b0000001,
      STEP_MODE    = 7'b0000010,
      STEP_ADDR_HI = 7'b0000100,
      STEP_ADDR_LO = 7'b0001000,
      STEP_LENGTH  = 7'b0010000,
      STEP_END     = 7'b0100000,
      STEP_STATUS  = 7'b1000000
   } step_type;

   typedef enum logic [1:0] {
      PH_SYNCING   = 2'd0,
      PH_SYNCED    = 2'd1,
      PH_RECEIVING = 2'd2
   } phase_type;

   localparam int EW = ksp_pkg::ENTRY_W;
   localparam int SW = ksp_pkg::SCAN_W;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;
   phase_type phase_ff, phase_in;
   logic [EW-1:0] cur_ff, cur_in;
   logic [8:0]    left_ff, left_in;
   logic [31:0]   acc_ff, acc_in;
   logic [ksp_pkg::ENTRIES-1:0] used_ff, used_in;
   logic [ksp_pkg::ENTRIES-1:0] vvalid_ff, vvalid_in;
   logic [EW-1:0] scan_k_ff, scan_k_in;
   logic [SW-1:0] scan_cnt_ff, scan_cnt_in;
   logic          with_start_ff, with_start_in;
   logic          wide_ff, wide_in;
   logic [2:0]    pend_ff, pend_in;
   ksp_pkg::cmd_type   cmd_ff, cmd_in;
   ksp_pkg::entry_type frame_ff, frame_in;
   ksp_pkg::rsp_type   rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;

   logic          prm_wr_en;
   logic [EW-1:0] prm_rd_addr;
   logic [ksp_pkg::ENTRY_BITS-1:0] prm_rd_data;
   logic          val_wr_en;
   logic [EW-1:0] val_wr_addr;
   logic [31:0]   val_wr_data;
   logic [EW-1:0] val_rd_addr;
   logic [31:0]   val_rd_data;

   ksp_pkg::entry_type rd_entry;
   ksp_pkg::mode_class_type mode_cls;
   logic [7:0]    mode_eff;
   logic [31:0]   acc_or;
   logic [EW-1:0] next_entry;
   logic          has_next;
   logic [EW-1:0] scan_next;

   // Entry parameters and last values
   ksp_ram #(.WIDTH(ksp_pkg::ENTRY_BITS), .DEPTH(ksp_pkg::ENTRIES)) u_param_ram (
      .clock   (clock),
      .wr_en   (prm_wr_en),
      .wr_addr (cmd_data.index),
      .wr_data (cmd_data.entry),
      .rd_addr (prm_rd_addr),
      .rd_data (prm_rd_data)
   );

   ksp_ram #(.WIDTH(32), .DEPTH(ksp_pkg::ENTRIES)) u_value_ram (
      .clock   (clock),
      .wr_en   (val_wr_en),
      .wr_addr (val_wr_addr),
      .wr_data (val_wr_data),
      .rd_addr (val_rd_addr),
      .rd_data (val_rd_data)
   );

   // Decode helpers; an entry not in use reads with mode zero
   always_comb begin
      rd_entry = ksp_pkg::entry_type'(prm_rd_data);
      mode_eff = used_ff[cur_ff] ? rd_entry.mode : 8'h00;
      mode_cls = ksp_pkg::classify_mode(mode_eff);
      acc_or = acc_ff | {24'h000000, cmd_data.data_byte};
      next_entry = cur_ff + 1'b1;
      has_next = (cur_ff != EW'(ksp_pkg::ENTRIES - 1)) && used_ff[next_entry];
      scan_next = (scan_k_ff == EW'(ksp_pkg::ENTRIES - 1)) ? '0 : scan_k_ff + 1'b1;
   end

   // Sequence one request at a time
   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      phase_in = phase_ff;
      cur_in = cur_ff;
      left_in = left_ff;
      acc_in = acc_ff;
      used_in = used_ff;
      vvalid_in = vvalid_ff;
      scan_k_in = scan_k_ff;
      scan_cnt_in = scan_cnt_ff;
      with_start_in = with_start_ff;
      wide_in = wide_ff;
      pend_in = pend_ff;
      cmd_in = cmd_ff;
      frame_in = frame_ff;
      rsp_in = rsp_ff;
      strobe_in = 1'b0;
      cmd_pop = 1'b0;
      prm_wr_en = 1'b0;
      prm_rd_addr = cur_ff;
      val_wr_en = 1'b0;
      val_wr_addr = cur_ff;
      val_wr_data = acc_or;
      val_rd_addr = cur_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cmd_in = cmd_data;
               unique case (cmd_data.op)
                  ksp_pkg::OP_RX: begin
                     priority if (phase_ff == PH_SYNCING &&
                                  cmd_data.data_byte == ksp_pkg::SYNC_BYTE) begin
                        with_start_in = 1'b1;
                        state_in = S_FRAME_RD;
                     end else if (phase_ff != PH_RECEIVING) begin
                        rsp_in = ksp_pkg::make_status(ksp_pkg::ST_CONTINUE);
                        strobe_in = 1'b1;
                     end else if (left_ff > 9'd1) begin
                        left_in = left_ff - 9'd1;
                        acc_in = acc_or << 8;
                        rsp_in = ksp_pkg::make_status(ksp_pkg::ST_CONTINUE);
                        strobe_in = 1'b1;
                     end else begin
                        // reply complete: store the value, fetch the conversion
                        left_in = '0;
                        acc_in = acc_or;
                        val_wr_en = 1'b1;
                        vvalid_in[cur_ff] = 1'b1;
                        state_in = S_REPORT;
                     end
                  end
                  ksp_pkg::OP_TX_DONE: begin
                     phase_in = PH_RECEIVING;
                  end
                  ksp_pkg::OP_START: begin
                     scan_k_in = cur_ff;
                     scan_cnt_in = '0;
                     state_in = S_SCAN;
                  end
                  ksp_pkg::OP_TIMEOUT: begin
                     vvalid_in[cur_ff] = 1'b0;
                     phase_in = PH_SYNCED;
                  end
                  ksp_pkg::OP_WRITE: begin
                     if (cmd_data.in_range) begin
                        prm_wr_en = 1'b1;
                        used_in[cmd_data.index] = (cmd_data.entry.mode != 8'h00);
                        vvalid_in[cmd_data.index] = 1'b0;
                     end
                  end
                  ksp_pkg::OP_READ: begin
                     prm_rd_addr = cmd_data.index;
                     val_rd_addr = cmd_data.index;
                     state_in = S_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // One table entry a cycle, circularly from the entry after current
         S_SCAN: begin
            if (used_ff[scan_next]) begin
               cur_in = scan_next;
               phase_in = PH_SYNCING;
               rsp_in = ksp_pkg::make_status(ksp_pkg::ST_CONTINUE);
               strobe_in = 1'b1;
               state_in = S_IDLE;
            end else if (scan_cnt_ff == SW'(ksp_pkg::ENTRIES - 1)) begin
               rsp_in = ksp_pkg::make_status(ksp_pkg::ST_IDLE);
               strobe_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               scan_k_in = scan_next;
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end

         S_READ: begin
            rsp_in = '0;
            rsp_in.kind = ksp_pkg::KIND_READ;
            rsp_in.index = cmd_ff.raw_index;
            rsp_in.last = 1'b1;
            if (cmd_ff.in_range) begin
               rsp_in.value = vvalid_ff[cmd_ff.index] ? val_rd_data : ksp_pkg::ALL_ONES;
               rsp_in.conversion = rd_entry.conversion;
            end else begin
               rsp_in.value = ksp_pkg::ALL_ONES;
            end
            strobe_in = 1'b1;
            state_in = S_IDLE;
         end

         // Report the value if its conversion is nonzero, then chain to the following entry if in use
         S_REPORT: begin
            if (rd_entry.conversion != 8'h00) begin
               rsp_in = '0;
               rsp_in.kind = ksp_pkg::KIND_VALUE;
               rsp_in.index = 5'(cur_ff);
               rsp_in.value = acc_ff;
               rsp_in.conversion = rd_entry.conversion;
               strobe_in = 1'b1;
            end
            if (has_next) begin
               cur_in = next_entry;
               prm_rd_addr = next_entry;
               with_start_in = 1'b0;
               state_in = S_FRAME_RD;
            end else begin
               phase_in = PH_SYNCED;
               pend_in = ksp_pkg::ST_OK;
               state_in = S_STATUS;
            end
         end

         S_FRAME_RD: begin
            frame_in = rd_entry;
            frame_in.mode = mode_eff;
            acc_in = '0;
            left_in = 9'(rd_entry.length);
            phase_in = PH_SYNCED;
            if (mode_cls == ksp_pkg::MODE_BAD) begin
               rsp_in = ksp_pkg::make_status(ksp_pkg::ST_UNSUPPORTED);
               strobe_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               wide_in = (mode_cls == ksp_pkg::MODE_WIDE);
               step_in = with_start_ff ? STEP_START : STEP_MODE;
               state_in = S_FRAME;
            end
         end

         // Emit one frame byte a cycle, then the sent status
         S_FRAME: begin
            strobe_in = 1'b1;
            unique case (step_ff)
               STEP_START: begin
                  rsp_in = ksp_pkg::make_tx(ksp_pkg::FRAME_START);
                  step_in = STEP_MODE;
               end
               STEP_MODE: begin
                  rsp_in = ksp_pkg::make_tx(frame_ff.mode);
                  step_in = wide_ff ? STEP_ADDR_HI : STEP_ADDR_LO;
               end
               STEP_ADDR_HI: begin
                  rsp_in = ksp_pkg::make_tx(frame_ff.address[15:8]);
                  step_in = STEP_ADDR_LO;
               end
               STEP_ADDR_LO: begin
                  rsp_in = ksp_pkg::make_tx(frame_ff.address[7:0]);
                  step_in = STEP_LENGTH;
               end
               STEP_LENGTH: begin
                  rsp_in = ksp_pkg::make_tx(frame_ff.length);
                  step_in = STEP_END;
               end
               STEP_END: begin
                  rsp_in = ksp_pkg::make_tx(ksp_pkg::FRAME_END);
                  step_in = STEP_STATUS;
               end
               STEP_STATUS: begin
                  rsp_in = ksp_pkg::make_status(ksp_pkg::ST_SENT);
                  state_in = S_IDLE;
               end
               default: begin
                  strobe_in = 1'b0;
                  state_in = S_IDLE;
               end
            endcase
         end

         S_STATUS: begin
            rsp_in = ksp_pkg::make_status(pend_ff);
            strobe_in = 1'b1;
            state_in = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= STEP_START;
         phase_ff <= PH_SYNCING;
         cur_ff <= '0;
         left_ff <= '0;
         acc_ff <= '0;
         used_ff <= '0;
         vvalid_ff <= '0;
         scan_k_ff <= '0;
         scan_cnt_ff <= '0;
         with_start_ff <= 1'b0;
         wide_ff <= 1'b0;
         pend_ff <= ksp_pkg::ST_CONTINUE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         phase_ff <= phase_in;
         cur_ff <= cur_in;
         left_ff <= left_in;
         acc_ff <= acc_in;
         used_ff <= used_in;
         vvalid_ff <= vvalid_in;
         scan_k_ff <= scan_k_in;
         scan_cnt_ff <= scan_cnt_in;
         with_start_ff <= with_start_in;
         wide_ff <= wide_in;
         pend_ff <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      frame_ff <= frame_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data = rsp_ff;

   // The final result of a request leaves the sequencer free
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && rsp_ff.last |-> state_ff == S_IDLE)
      else $error("final result while sequencer still busy");

   // Frame bytes go out only once the link has been claimed
   a_tx_synced: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && rsp_ff.kind == ksp_pkg::KIND_TX |-> phase_ff == PH_SYNCED)
      else $error("frame byte sent outside synced phase");

   // An unsupported mode leaves the link synced
   a_bad_mode: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && rsp_ff.kind == ksp_pkg::KIND_STATUS &&
      rsp_ff.status == ksp_pkg::ST_UNSUPPORTED |-> phase_ff == PH_SYNCED)
      else $error("unsupported mode status with wrong link phase");

   // The scan visits no more entries than the table holds
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> scan_cnt_ff < SW'(ksp_pkg::ENTRIES))
      else $error("entry scan ran past the table");

endmodule
